[rtl/core/imtcf_pkg.sv]
`default_nettype none
package imtcf_pkg;

  // Field widths
  localparam int RAW_W     = 16;
  localparam int OFF_W     = 24;
  localparam int RATE_W    = 28;
  localparam int ANG_OUT_W = 25;

  // Filter and blend weights, Q.24, unsigned
  localparam int WB     = 24;
  localparam int WTW    = 24;
  localparam int W_HALF = 8388608;
  localparam int W_SLOW = 838861;
  localparam int W_ACC  = 167772;
  localparam int W_DT   = 16777;
  localparam int W_KEEP = 16760439;

  localparam int RATE_MAX = 134217727;
  localparam int RATE_MIN = -134217728;

  // Gyro scaling: round(raw * 10 * 2^F / 164), ties away from zero
  localparam int DIV_CONST = 164;
  localparam int DIV_BIAS  = 82;
  localparam int DIV_REM_W = 8;

  // CORDIC angle accumulator, degrees Q.24
  localparam int CORDIC_ACC_W     = 34;
  localparam int ATAN_FRAC        = 24;
  localparam int CORDIC_MAX_STEPS = 24;

  typedef enum logic [1:0] {
    CFG_CAL   = 2'd0,
    CFG_OFF_X = 2'd1,
    CFG_OFF_Y = 2'd2,
    CFG_OFF_Z = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_GX    = 4'd0,
    OP_GY    = 4'd1,
    OP_GZ    = 4'd2,
    OP_AX    = 4'd3,
    OP_AZ    = 4'd4,
    OP_YAW   = 4'd5,
    OP_PDT   = 4'd6,
    OP_PKEEP = 4'd7,
    OP_PACC  = 4'd8
  } op_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_DIVW  = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_MULWB = 9'b000010000,
    S_COR   = 9'b000100000,
    S_CORW  = 9'b001000000,
    S_ANGLE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  // atan(2^-i) in degrees, Q.24
  function automatic logic signed [CORDIC_ACC_W-1:0] atan_q24(input logic [4:0] idx);
    logic signed [CORDIC_ACC_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sd754974720;
      5'd1:  v = 34'sd445687602;
      5'd2:  v = 34'sd235489088;
      5'd3:  v = 34'sd119537938;
      5'd4:  v = 34'sd60000934;
      5'd5:  v = 34'sd30029717;
      5'd6:  v = 34'sd15018523;
      5'd7:  v = 34'sd7509720;
      5'd8:  v = 34'sd3754917;
      5'd9:  v = 34'sd1877466;
      5'd10: v = 34'sd938734;
      5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;
      5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;
      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;
      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;
      5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;
      5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;
      5'd23: v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/core/imtcf_ifs.sv]
`default_nettype none
interface imtcf_sample_if import imtcf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RAW_W-1:0] accel_x_raw;
  logic signed [RAW_W-1:0] accel_z_raw;
  logic signed [RAW_W-1:0] gyro_x_raw;
  logic signed [RAW_W-1:0] gyro_y_raw;
  logic signed [RAW_W-1:0] gyro_z_raw;

  modport source (output valid, accel_x_raw, accel_z_raw, gyro_x_raw, gyro_y_raw,
                  gyro_z_raw, input ready);
  modport sink (input valid, accel_x_raw, accel_z_raw, gyro_x_raw, gyro_y_raw,
                gyro_z_raw, output ready);
endinterface

interface imtcf_result_if import imtcf_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [ANG_OUT_W-1:0] pitch_angle;
  logic signed [ANG_OUT_W-1:0] yaw_angle;
  logic signed [ANG_OUT_W-1:0] accel_pitch;
  logic signed [RATE_W-1:0]    gyro_rate_x_filtered;
  logic signed [RATE_W-1:0]    gyro_rate_y_filtered;
  logic signed [RATE_W-1:0]    gyro_rate_z_filtered;

  modport source (output valid, pitch_angle, yaw_angle, accel_pitch, gyro_rate_x_filtered,
                  gyro_rate_y_filtered, gyro_rate_z_filtered, input ready);
  modport sink (input valid, pitch_angle, yaw_angle, accel_pitch, gyro_rate_x_filtered,
                gyro_rate_y_filtered, gyro_rate_z_filtered, output ready);
endinterface
`default_nettype wire

[rtl/core/imtcf_div164.sv]
`default_nettype none
// Divide by 164 for the gyro scaling: quot = floor((num * 2^FRAC + 82) / 164),
// num = 10*|raw|. Split num = 164*hi + lo, then
// quot = hi * 2^FRAC + floor((lo * 2^FRAC + 82) / 164).
// Each quotient comes from an exact reciprocal multiply, one per cycle; done_o
// pulses once start_i has passed through v1_q, v2_q and done_q.
module imtcf_div164 import imtcf_pkg::*; #(
  parameter int FRAC = 16,
  parameter int NW   = 36
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [RAW_W+3:0]  num_i,
  output logic                   done_o,
  output logic [NW-1:0]          quot_o
);

  localparam int MW  = RAW_W + 4;               // numerator
  localparam int K1  = MW + DIV_REM_W;          // first reciprocal shift
  localparam int RW2 = DIV_REM_W + FRAC;        // remainder numerator
  localparam int K2  = RW2 + DIV_REM_W;         // second reciprocal shift
  localparam logic [MW:0]  C1 = (MW + 1)'(((64'sd1 <<< K1) + DIV_CONST - 1) / DIV_CONST);
  localparam logic [RW2:0] C2 = (RW2 + 1)'(((64'sd1 <<< K2) + DIV_CONST - 1) / DIV_CONST);

  logic                 v1_q, v2_q, done_q;
  logic [MW-1:0]        m_q;
  logic [MW-1:0]        hi_q;
  logic [DIV_REM_W-1:0] lo_q;
  logic [NW-1:0]        quo_q;
  logic [2*MW:0]        prod1;
  logic [MW-1:0]        hi;
  logic [MW-1:0]        lo_full;
  logic [DIV_REM_W-1:0] lo;
  logic [RW2-1:0]       r;
  logic [2*RW2:0]       prod2;
  logic [FRAC-1:0]      t;

  always_comb begin
    prod1   = m_q * C1;
    hi      = MW'(prod1[2*MW:K1]);
    lo_full = m_q - hi * MW'(DIV_CONST);
    lo      = lo_full[DIV_REM_W-1:0];
    r       = {lo_q, {FRAC{1'b0}}} + RW2'(DIV_BIAS);
    prod2   = r * C2;
    t       = prod2[K2 +: FRAC];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) m_q <= num_i;
    if (v1_q) begin
      hi_q <= hi;
      lo_q <= lo;
    end
    if (v2_q) quo_q <= NW'({hi_q, t});
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

[rtl/core/imtcf_cordic.sv]
`default_nettype none
// Vectoring CORDIC, one micro-rotation per cycle; angle in degrees Q.24.
module imtcf_cordic import imtcf_pkg::*; #(
  parameter int CW    = 24,
  parameter int STEPS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic signed [CW-1:0]           x_i,
  input  wire logic signed [CW-1:0]           y_i,
  output logic                                done_o,
  output logic signed [CORDIC_ACC_W-1:0]      angle_o
);

  localparam int NIT = (STEPS < CORDIC_MAX_STEPS) ? STEPS : CORDIC_MAX_STEPS;
  localparam int IW  = $clog2(NIT);
  localparam logic signed [CORDIC_ACC_W-1:0] HALF_TURN = CORDIC_ACC_W'(180) <<< ATAN_FRAC;

  logic                           busy_q;
  logic                           done_q;
  logic [IW-1:0]                  i_q;
  logic signed [CW-1:0]           x_q;
  logic signed [CW-1:0]           y_q;
  logic signed [CORDIC_ACC_W-1:0] acc_q;
  logic signed [CW-1:0]           xs;
  logic signed [CW-1:0]           ys;
  logic signed [CORDIC_ACC_W-1:0] step_ang;

  always_comb begin
    xs       = x_q >>> i_q;
    ys       = y_q >>> i_q;
    step_ang = atan_q24(5'(i_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        i_q <= '0;
        // a zero vector has no direction: report zero at once
        if (x_i == '0 && y_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        i_q <= i_q + IW'(1);
        if (i_q == IW'(NIT - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // pre-rotate the left half plane by a half turn
      if (x_i < 0) begin
        x_q   <= -x_i;
        y_q   <= -y_i;
        acc_q <= (y_i >= 0) ? HALF_TURN : -HALF_TURN;
      end else begin
        x_q   <= x_i;
        y_q   <= y_i;
        acc_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q   <= x_q + ys;
        y_q   <= y_q - xs;
        acc_q <= acc_q + step_ang;
      end else begin
        x_q   <= x_q - ys;
        y_q   <= y_q + xs;
        acc_q <= acc_q - step_ang;
      end
    end
  end

  assign done_o  = done_q;
  assign angle_o = acc_q;

endmodule
`default_nettype wire

[rtl/core/imu_tilt_complementary_filter_core.sv]
`default_nettype none
// Pitch/yaw tilt estimator for one IMU sample per beat. Each accepted sample
// (raw accel x/z and gyro x/y/z) produces exactly one result beat: fused pitch,
// integrated yaw wrapped to +-180 deg, accelerometer pitch from a CORDIC
// atan2, and the three low-passed gyro rates, all two's complement with
// FRAC_BITS fraction bits. Configuration (calibrated mode, three gyro offsets
// in deg/s) goes in through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write
// it only while the block is idle (the block itself does not enforce this),
// and a write then takes effect on the next sample. The block handles one
// sample at a time and drops ready while it works; a sample takes less time
// when the tilt is steeper than 90 deg and when both filtered accels are
// zero. The three gyro axes each go through a two-step reciprocal divide by
// 164; the rest is the shared multiplier (30x25 at the defaults) used for
// every filter, integration and blend step, and one CORDIC micro-rotation
// per cycle. A finished result waits in an output register, so the next
// sample is taken while the result is still pending; a result that is still
// waiting when the next one is done holds the block until the output
// register frees.
module imu_tilt_complementary_filter_core import imtcf_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [OFF_W-1:0] cfg_data_i,
  imtcf_sample_if.sink          sample_i,
  imtcf_result_if.source        result_o
);

  localparam int AW    = FRAC_BITS + 10;           // angle registers
  localparam int DW    = (AW > 30) ? AW : 30;      // multiplier signed operand
  localparam int PW    = DW + WTW + 1;             // product
  localparam int SW    = PW + 1;                   // sum of two products
  localparam int AFW   = FRAC_BITS + 5;            // filtered accel
  localparam int CW    = FRAC_BITS + 8;            // CORDIC vector
  localparam int NW    = FRAC_BITS + 20;           // divider quotient
  // scaled rate before clamp
  localparam int RW    = (FRAC_BITS + 15 > RATE_W) ? FRAC_BITS + 15 : RATE_W + 1;
  localparam int EW    = CORDIC_ACC_W + 2;
  localparam int SHIFT = ATAN_FRAC - FRAC_BITS;

  localparam logic signed [PW-1:0] P_HALF = PW'(1) <<< (WB - 1);
  localparam logic signed [SW-1:0] S_HALF = SW'(1) <<< (WB - 1);
  localparam logic signed [PW-1:0] P_RMAX = PW'(RATE_MAX);
  localparam logic signed [PW-1:0] P_RMIN = PW'(RATE_MIN);
  localparam logic signed [RW-1:0] R_RMAX = RW'(RATE_MAX);
  localparam logic signed [RW-1:0] R_RMIN = RW'(RATE_MIN);
  localparam logic signed [AW-1:0] ONE80  = AW'(180) <<< FRAC_BITS;
  localparam logic signed [AW-1:0] NINETY = AW'(90) <<< FRAC_BITS;
  localparam logic signed [AW-1:0] FULL   = AW'(360) <<< FRAC_BITS;
  localparam logic signed [EW-1:0] E_180  = EW'(180) <<< FRAC_BITS;
  localparam logic signed [SW-1:0] S_180  = SW'(180) <<< FRAC_BITS;
  localparam logic signed [EW-1:0] E_RND  = (EW'(1) <<< SHIFT) >>> 1;

  state_e state_q, state_d;
  op_e    op_q;
  logic [1:0] axis_q;

  // configuration
  logic                    cal_q;
  logic signed [OFF_W-1:0] off_q [3];

  // sample and filter state
  logic signed [RAW_W-1:0]  ax_raw_q, az_raw_q;
  logic signed [RAW_W-1:0]  gyro_raw_q [3];
  logic signed [RATE_W-1:0] rate_q [3];
  logic signed [RATE_W-1:0] gf_q [3];
  logic signed [RATE_W-1:0] gf_prev [3];
  logic signed [AFW-1:0]    afx_q, afz_q;
  logic signed [AW-1:0]     pitch_q, yaw_q, accp_q, ptmp_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [SW-1:0]     sum_q;
  logic                     seeded_q, primed_q;

  // output register
  logic                        out_valid_q;
  logic signed [ANG_OUT_W-1:0] out_pitch_q, out_yaw_q, out_accp_q;
  logic signed [RATE_W-1:0]    out_gx_q, out_gy_q, out_gz_q;
  logic                        out_free;

  // gyro scaling
  logic signed [RAW_W-1:0] gyro_sel;
  logic [RAW_W:0]          mag;
  logic [RAW_W+3:0]        a10;
  logic [NW-1:0]           div_quot;
  logic                    div_start, div_done;
  logic signed [RW-1:0]    q_mag, q_signed, q_off;
  logic signed [RATE_W-1:0] rate_sat;

  // multiplier and write-back
  logic signed [DW-1:0]  mul_a;
  logic [WTW-1:0]        mul_b;
  logic signed [PW-1:0]  prod_d;
  logic signed [PW-1:0]  rnd;
  logic signed [PW-1:0]  wb_base;
  logic signed [PW-1:0]  sum_wb;
  logic signed [RATE_W-1:0] rate_wb;
  logic signed [AFW-1:0] ax_sc, az_sc;
  logic signed [AW-1:0]  yaw_sum, yaw_wrap;
  logic signed [SW-1:0]  psum;
  logic signed [AW-1:0]  pitch_fin;

  // CORDIC
  logic                           cor_start, cor_done;
  logic signed [CORDIC_ACC_W-1:0] cor_angle;
  logic signed [EW-1:0]           ang_e, nang_e;
  logic signed [AW-1:0]           accp_d;
  logic                           steep;

  imtcf_div164 #(.FRAC(FRAC_BITS), .NW(NW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (a10),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  imtcf_cordic #(.CW(CW), .STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cor_start),
    .x_i    (CW'(afz_q)),
    .y_i    (CW'(afx_q)),
    .done_o (cor_done),
    .angle_o(cor_angle)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q    <= 1'b0;
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CAL:   cal_q    <= cfg_data_i[0];
        CFG_OFF_X: off_q[0] <= cfg_data_i;
        CFG_OFF_Y: off_q[1] <= cfg_data_i;
        CFG_OFF_Z: off_q[2] <= cfg_data_i;
      endcase
    end
  end

  // Gyro scaling: sign-magnitude, the divider folds in the rounding bias
  always_comb begin
    gyro_sel = gyro_raw_q[axis_q];
    mag      = gyro_sel[RAW_W-1] ? -{gyro_sel[RAW_W-1], gyro_sel}
                                 : {gyro_sel[RAW_W-1], gyro_sel};
    a10      = ({3'b000, mag} << 3) + ({3'b000, mag} << 1);
    q_mag    = $signed({1'b0, div_quot[RW-2:0]});
    q_signed = gyro_sel[RAW_W-1] ? -q_mag : q_mag;
    q_off    = cal_q ? q_signed - RW'(off_q[axis_q]) : q_signed;
    if (q_off > R_RMAX) begin
      rate_sat = R_RMAX[RATE_W-1:0];
    end else if (q_off < R_RMIN) begin
      rate_sat = R_RMIN[RATE_W-1:0];
    end else begin
      rate_sat = q_off[RATE_W-1:0];
    end
  end

  // Multiplier operand select; the gyro filters read as zero until primed
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      gf_prev[k] = primed_q ? gf_q[k] : '0;
    end
    ax_sc = AFW'(ax_raw_q) <<< (FRAC_BITS - 12);
    az_sc = AFW'(az_raw_q) <<< (FRAC_BITS - 12);
    mul_a   = '0;
    mul_b   = '0;
    wb_base = '0;
    case (op_q)
      OP_GX: begin
        mul_a   = DW'(rate_q[0]) - DW'(gf_prev[0]);
        mul_b   = cal_q ? WTW'(W_HALF) : WTW'(W_SLOW);
        wb_base = PW'(gf_prev[0]);
      end
      OP_GY: begin
        mul_a   = DW'(rate_q[1]) - DW'(gf_prev[1]);
        mul_b   = cal_q ? WTW'(W_HALF) : WTW'(W_SLOW);
        wb_base = PW'(gf_prev[1]);
      end
      OP_GZ: begin
        mul_a   = DW'(rate_q[2]) - DW'(gf_prev[2]);
        mul_b   = cal_q ? WTW'(W_HALF) : WTW'(W_SLOW);
        wb_base = PW'(gf_prev[2]);
      end
      OP_AX: begin
        mul_a   = DW'(ax_sc) - DW'(afx_q);
        mul_b   = WTW'(W_ACC);
        wb_base = PW'(afx_q);
      end
      OP_AZ: begin
        mul_a   = DW'(az_sc) - DW'(afz_q);
        mul_b   = WTW'(W_ACC);
        wb_base = PW'(afz_q);
      end
      OP_YAW: begin
        mul_a   = DW'(rate_q[2]);
        mul_b   = WTW'(W_DT);
        wb_base = PW'(yaw_q);
      end
      OP_PDT: begin
        mul_a   = DW'(rate_q[1]);
        mul_b   = WTW'(W_DT);
        wb_base = PW'(pitch_q);
      end
      OP_PKEEP: begin
        mul_a = DW'(ptmp_q);
        mul_b = WTW'(W_KEEP);
      end
      OP_PACC: begin
        mul_a = DW'(accp_q);
        mul_b = WTW'(W_DT);
      end
      default: begin
        mul_a = '0;
      end
    endcase
    prod_d = mul_a * $signed({1'b0, mul_b});
  end

  // Write-back: round the registered product, add it to its base
  always_comb begin
    rnd    = (prod_q + P_HALF) >>> WB;
    sum_wb = wb_base + rnd;
    if (sum_wb > P_RMAX) begin
      rate_wb = P_RMAX[RATE_W-1:0];
    end else if (sum_wb < P_RMIN) begin
      rate_wb = P_RMIN[RATE_W-1:0];
    end else begin
      rate_wb = sum_wb[RATE_W-1:0];
    end
    // yaw wraps once per increment
    yaw_sum = sum_wb[AW-1:0];
    if (yaw_sum > ONE80) begin
      yaw_wrap = yaw_sum - FULL;
    end else if (yaw_sum < -ONE80) begin
      yaw_wrap = yaw_sum + FULL;
    end else begin
      yaw_wrap = yaw_sum;
    end
    // blend: keep-weighted pitch plus dt-weighted accel pitch
    psum = (sum_q + SW'(prod_q) + S_HALF) >>> WB;
    if (psum > S_180) begin
      pitch_fin = ONE80;
    end else if (psum < -S_180) begin
      pitch_fin = -ONE80;
    end else begin
      pitch_fin = psum[AW-1:0];
    end
  end

  // Accel pitch: round the Q.24 angle to Q.F, negate, saturate
  always_comb begin
    ang_e  = (EW'(cor_angle) + E_RND) >>> SHIFT;
    nang_e = -ang_e;
    if (nang_e > E_180) begin
      accp_d = ONE80;
    end else if (nang_e < -E_180) begin
      accp_d = -ONE80;
    end else begin
      accp_d = nang_e[AW-1:0];
    end
    steep = (accp_q > NINETY) || (accp_q < -NINETY);
  end

  assign out_free = !out_valid_q || result_o.ready;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    cor_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (sample_i.valid) state_d = S_DIV;
      end
      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) state_d = (axis_q == 2'd2) ? S_MUL : S_DIV;
      end
      S_MUL: begin
        state_d = S_MULWB;
      end
      S_MULWB: begin
        case (op_q)
          OP_AZ:   state_d = S_COR;
          OP_PACC: state_d = S_DONE;
          default: state_d = S_MUL;
        endcase
      end
      S_COR: begin
        cor_start = 1'b1;
        state_d   = S_CORW;
      end
      S_CORW: begin
        if (cor_done) state_d = S_ANGLE;
      end
      S_ANGLE: begin
        state_d = steep ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_GX;
      axis_q      <= '0;
      primed_q    <= 1'b0;
      seeded_q    <= 1'b0;
      gf_q[0]     <= '0;
      gf_q[1]     <= '0;
      gf_q[2]     <= '0;
      afx_q       <= '0;
      afz_q       <= '0;
      pitch_q     <= '0;
      yaw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          axis_q <= '0;
        end
        S_DIVW: begin
          if (div_done) begin
            axis_q <= axis_q + 2'd1;
            if (axis_q == 2'd2) op_q <= OP_GX;
          end
        end
        S_MULWB: begin
          op_q <= op_e'(op_q + 4'd1);
          case (op_q)
            OP_GX:   gf_q[0] <= rate_wb;
            OP_GY:   gf_q[1] <= rate_wb;
            OP_GZ: begin
              gf_q[2]  <= rate_wb;
              primed_q <= 1'b1;
            end
            OP_AX:   afx_q   <= sum_wb[AFW-1:0];
            OP_AZ:   afz_q   <= sum_wb[AFW-1:0];
            OP_YAW:  yaw_q   <= yaw_wrap;
            OP_PACC: pitch_q <= pitch_fin;
            default: ;
          endcase
        end
        S_ANGLE: begin
          // seed on the first sample; follow the accel pitch when steep
          op_q     <= OP_YAW;
          seeded_q <= 1'b1;
          if (steep || !seeded_q) pitch_q <= accp_q;
        end
        default: ;
      endcase
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      ax_raw_q      <= sample_i.accel_x_raw;
      az_raw_q      <= sample_i.accel_z_raw;
      gyro_raw_q[0] <= sample_i.gyro_x_raw;
      gyro_raw_q[1] <= sample_i.gyro_y_raw;
      gyro_raw_q[2] <= sample_i.gyro_z_raw;
    end
    if (state_q == S_DIVW && div_done) rate_q[axis_q] <= rate_sat;
    if (state_q == S_MUL) prod_q <= prod_d;
    if (state_q == S_MULWB && op_q == OP_PDT) ptmp_q <= sum_wb[AW-1:0];
    if (state_q == S_MULWB && op_q == OP_PKEEP) sum_q <= SW'(prod_q);
    if (state_q == S_CORW && cor_done) accp_q <= accp_d;
    if (state_q == S_DONE && out_free) begin
      out_pitch_q <= ANG_OUT_W'(pitch_q);
      out_yaw_q   <= ANG_OUT_W'(yaw_q);
      out_accp_q  <= ANG_OUT_W'(accp_q);
      out_gx_q    <= gf_q[0];
      out_gy_q    <= gf_q[1];
      out_gz_q    <= gf_q[2];
    end
  end

  assign sample_i.ready                = (state_q == S_IDLE);
  assign result_o.valid                = out_valid_q;
  assign result_o.pitch_angle          = out_pitch_q;
  assign result_o.yaw_angle            = out_yaw_q;
  assign result_o.accel_pitch          = out_accp_q;
  assign result_o.gyro_rate_x_filtered = out_gx_q;
  assign result_o.gyro_rate_y_filtered = out_gy_q;
  assign result_o.gyro_rate_z_filtered = out_gz_q;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.valid && sample_i.ready |=> !sample_i.ready)
    else $error("ready held after a sample beat");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !div_done && !cor_done)
    else $error("arithmetic unit finished while idle");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (yaw_q <= ONE80) && (yaw_q >= -ONE80))
    else $error("yaw left the wrapped range");

endmodule
`default_nettype wire

[tb/tb_imu_tilt_complementary_filter_core.sv]
module tb_imu_tilt_complementary_filter_core;
  import imtcf_pkg::*;

  typedef struct packed {
    logic signed [ANG_OUT_W-1:0] pitch;
    logic signed [ANG_OUT_W-1:0] yaw;
    logic signed [ANG_OUT_W-1:0] acc_pitch;
    logic signed [RATE_W-1:0]    rate_x;
    logic signed [RATE_W-1:0]    rate_y;
    logic signed [RATE_W-1:0]    rate_z;
  } tilt_t;

  localparam int FRAC      = 16;
  localparam int STEPS     = 16;
  localparam int WDOG_MAX  = 4000;
  localparam longint ONE80 = 64'sd180 <<< FRAC;
  localparam longint NINETY = 64'sd90 <<< FRAC;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_CAL;
  logic [OFF_W-1:0] cfg_data_i = '0;

  imtcf_sample_if sample_if ();
  imtcf_result_if result_if ();

  imu_tilt_complementary_filter_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (sample_if.sink),
    .result_o   (result_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the filter state and the configuration registers.
  logic   cal_mode;
  longint off_x, off_y, off_z;
  longint gfx, gfy, gfz, afx, afz, pitch_st, yaw_st;
  bit     seeded;
  longint atan_tab [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717, 15018523,
    7509720, 3754917, 1877466, 938734, 469367, 234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115};

  tilt_t expected_tilt [$];
  int    err_cnt = 0;
  int    beats_out = 0;
  int    beats_in = 0;
  int    steep_cnt = 0;
  int    idle_cnt = 0;

  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shr(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint scale_rate(logic signed [RAW_W-1:0] raw, longint off);
    longint n, q;
    n = longint'(raw) * 10 * (64'sd1 <<< FRAC);
    q = n >= 0 ? (n + 82) / 164 : -((-n + 82) / 164);
    if (cal_mode) q -= off;
    return sat(q, RATE_MIN, RATE_MAX);
  endfunction

  function automatic longint smooth(longint f, longint p, longint w);
    return f + rnd_shr((p - f) * w, WB);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint acc, xs, ys;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      acc = (y >= 0) ? (64'sd180 <<< 24) : -(64'sd180 <<< 24);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = fl_shr(x, i);
      ys = fl_shr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; acc += atan_tab[i];
      end else begin
        x -= ys; y += xs; acc -= atan_tab[i];
      end
    end
    return acc;
  endfunction

  task automatic reset_shadow();
    cal_mode = 1'b0;
    off_x = 0; off_y = 0; off_z = 0;
    gfx = 0; gfy = 0; gfz = 0; afx = 0; afz = 0;
    pitch_st = 0; yaw_st = 0;
    seeded = 1'b0;
  endtask

  // Advance the shadow state by one sample and queue the tilt it yields.
  task automatic predict_tilt(input logic signed [RAW_W-1:0] ax_r, az_r, gx_r, gy_r, gz_r);
    longint w, px, py, pz, ang, ap, p;
    tilt_t  t;
    w  = cal_mode ? W_HALF : W_SLOW;
    px = scale_rate(gx_r, off_x);
    py = scale_rate(gy_r, off_y);
    pz = scale_rate(gz_r, off_z);
    gfx = sat(smooth(gfx, px, w), RATE_MIN, RATE_MAX);
    gfy = sat(smooth(gfy, py, w), RATE_MIN, RATE_MAX);
    gfz = sat(smooth(gfz, pz, w), RATE_MIN, RATE_MAX);
    afx = smooth(afx, longint'(ax_r) * (64'sd1 <<< (FRAC - 12)), W_ACC);
    afz = smooth(afz, longint'(az_r) * (64'sd1 <<< (FRAC - 12)), W_ACC);
    ang = rnd_shr(vector_angle(afx, afz), 24 - FRAC);
    ap  = sat(-ang, -ONE80, ONE80);
    if (!seeded) begin
      seeded = 1'b1;
      pitch_st = ap;
    end
    if (ap > NINETY || ap < -NINETY) begin
      pitch_st = ap;
      steep_cnt++;
    end else begin
      p = pitch_st + rnd_shr(py * W_DT, WB);
      p = rnd_shr(p * W_KEEP + ap * W_DT, WB);
      pitch_st = sat(p, -ONE80, ONE80);
      yaw_st += rnd_shr(pz * W_DT, WB);
      if (yaw_st > ONE80) yaw_st -= 2 * ONE80;
      else if (yaw_st < -ONE80) yaw_st += 2 * ONE80;
    end
    t.pitch = pitch_st[ANG_OUT_W-1:0];
    t.yaw = yaw_st[ANG_OUT_W-1:0];
    t.acc_pitch = ap[ANG_OUT_W-1:0];
    t.rate_x = gfx[RATE_W-1:0];
    t.rate_y = gfy[RATE_W-1:0];
    t.rate_z = gfz[RATE_W-1:0];
    expected_tilt.push_back(t);
  endtask

  // Sender bursts: beats left in the current burst before the next gap.
  int burst_left = 0;

  initial begin
    sample_if.valid = 1'b0;
    sample_if.accel_x_raw = '0;
    sample_if.accel_z_raw = '0;
    sample_if.gyro_x_raw = '0;
    sample_if.gyro_y_raw = '0;
    sample_if.gyro_z_raw = '0;
    result_if.ready = 1'b0;
  end

  // Valid stays high between beats of a burst; drop it only for a gap.
  task automatic send_sample(input logic signed [RAW_W-1:0] ax_r, az_r, gx_r, gy_r, gz_r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        sample_if.valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
    burst_left--;
    sample_if.valid <= 1'b1;
    sample_if.accel_x_raw <= ax_r;
    sample_if.accel_z_raw <= az_r;
    sample_if.gyro_x_raw <= gx_r;
    sample_if.gyro_y_raw <= gy_r;
    sample_if.gyro_z_raw <= gz_r;
    predict_tilt(ax_r, az_r, gx_r, gy_r, gz_r);
    do @(posedge clk_i); while (!sample_if.ready);
    beats_in++;
  endtask

  // Drop valid, then wait for every queued result.
  task automatic drain();
    sample_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_tilt.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input longint val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[OFF_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CAL:   cal_mode = val[0];
      CFG_OFF_X: off_x = longint'(signed'(val[OFF_W-1:0]));
      CFG_OFF_Y: off_y = longint'(signed'(val[OFF_W-1:0]));
      default:   off_z = longint'(signed'(val[OFF_W-1:0]));
    endcase
  endtask

  function automatic logic signed [RAW_W-1:0] rand_raw();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return RAW_W'($urandom_range(0, 64) - 32);
      default: return RAW_W'($urandom());
    endcase
  endfunction

  // Receiver stall pattern: a rotating mask plus random stalls, off at times.
  logic [15:0] stall_mask = 16'b1011_0010_0000_1100;
  int stall_mode = 0;
  always @(posedge clk_i) begin
    stall_mask <= {stall_mask[14:0], stall_mask[15]};
    if ($urandom_range(0, 255) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: result_if.ready <= 1'b1;
      1: result_if.ready <= ~stall_mask[0];
      default: result_if.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Check each result beat against the oldest queued tilt.
  always @(posedge clk_i) begin
    tilt_t e;
    if (rst_ni && result_if.valid && result_if.ready) begin
      beats_out++;
      if (expected_tilt.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        e = expected_tilt.pop_front();
        if (result_if.pitch_angle !== e.pitch) begin
          $error("pitch_angle exp %0d got %0d", e.pitch, result_if.pitch_angle);
          err_cnt++;
        end
        if (result_if.yaw_angle !== e.yaw) begin
          $error("yaw_angle exp %0d got %0d", e.yaw, result_if.yaw_angle);
          err_cnt++;
        end
        if (result_if.accel_pitch !== e.acc_pitch) begin
          $error("accel_pitch exp %0d got %0d", e.acc_pitch, result_if.accel_pitch);
          err_cnt++;
        end
        if (result_if.gyro_rate_x_filtered !== e.rate_x) begin
          $error("gyro_rate_x_filtered exp %0d got %0d", e.rate_x,
                 result_if.gyro_rate_x_filtered);
          err_cnt++;
        end
        if (result_if.gyro_rate_y_filtered !== e.rate_y) begin
          $error("gyro_rate_y_filtered exp %0d got %0d", e.rate_y,
                 result_if.gyro_rate_y_filtered);
          err_cnt++;
        end
        if (result_if.gyro_rate_z_filtered !== e.rate_z) begin
          $error("gyro_rate_z_filtered exp %0d got %0d", e.rate_z,
                 result_if.gyro_rate_z_filtered);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk_i) begin
    if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > WDOG_MAX) begin
      $display("watchdog: no beat for %0d cycles", WDOG_MAX);
      $display("tb_imu_tilt_complementary_filter_core: errors");
      $finish;
    end
  end

  // Directed: field extremes, zero vector, negative z on both sides, steep tilt.
  task automatic test_directed_edges();
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sd0, 16'sd0, 16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sd4096, 16'sh8000, 16'sd82, -16'sd82, 16'sd1);
    send_sample(16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sh8000, 16'sd0, 16'sd0, 16'sd0);
    repeat (4) send_sample(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    repeat (4) send_sample(16'sh7fff, 16'sd0, 16'sd164, 16'sd164, 16'sd164);
    send_sample(16'sd0, 16'sh7fff, -16'sd1, -16'sd1, -16'sd1);
    drain();
  endtask

  // Calibrated mode with extreme offsets drives the rate clamps.
  task automatic test_calibrated_extremes();
    write_reg(CFG_CAL, 1);
    write_reg(CFG_OFF_X, 64'sd8388607);
    write_reg(CFG_OFF_Y, -64'sd8388608);
    write_reg(CFG_OFF_Z, 64'sd12345);
    repeat (3) send_sample(16'sd1000, 16'sd4096, 16'sh8000, 16'sh7fff, 16'sh7fff);
    repeat (3) send_sample(-16'sd1000, 16'sd4096, 16'sh7fff, 16'sh8000, 16'sh8000);
    drain();
  endtask

  // Random phases: mostly smooth motion near level, some noise and steep tilts.
  task automatic test_random_motion(input int n);
    logic signed [RAW_W-1:0] ax, az;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        ax = rand_raw();
        az = rand_raw();
      end else begin
        ax = RAW_W'($urandom_range(0, 8000) - 4000);
        az = RAW_W'($urandom_range(0, 2000) + 3000);
      end
      send_sample(ax, az, rand_raw(), rand_raw(), rand_raw());
    end
    drain();
  endtask

  task automatic new_settings();
    write_reg(CFG_CAL, $urandom_range(0, 1));
    write_reg(CFG_OFF_X, longint'($urandom_range(0, 16777215)) - 8388608);
    write_reg(CFG_OFF_Y, longint'($urandom_range(0, 4000)) - 2000);
    write_reg(CFG_OFF_Z, longint'($urandom_range(0, 16777215)) - 8388608);
  endtask

  initial begin
    reset_shadow();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_calibrated_extremes();
    for (int ph = 0; ph < 5; ph++) begin
      new_settings();
      test_random_motion(105);
    end
    write_reg(CFG_CAL, 0);
    write_reg(CFG_OFF_X, 0);
    test_random_motion(10);
    $display("covered %0d samples, %0d results, %0d steep-tilt samples", beats_in,
             beats_out, steep_cnt);
    $display("across reset defaults, extreme offsets and five random register sets");
    if (err_cnt == 0 && expected_tilt.size() == 0) begin
      $display("tb_imu_tilt_complementary_filter_core: clean");
    end else begin
      $display("tb_imu_tilt_complementary_filter_core: errors");
    end
    $finish;
  end

endmodule
